[rtl/double_ended_queue_defines.svh]
// Assertion macros shared by the double-ended queue checkers.
`ifndef DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define DEQ_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define DEQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/deq_pkg.sv]
// Shared types and constants for the double-ended queue.
package deq_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int DATA_W        = 32;
    localparam int CMD_W         = 3;
    localparam int STAT_W        = 2;
    localparam int POS_W         = 4;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_DUMP       = 3'd4
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

endpackage

[rtl/deq_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/double_ended_queue.sv]
// Push: one item per cycle, result in the cycle after start; busy stays low.
// Pop: result follows the registered store read and S_POP; busy is high for one cycle.
// Dump of N entries: first result after the store read, then one per cycle; busy in S_DUMP.
// Empty pop or dump gives its status result in the cycle after start.
// Synchronous active-low reset empties the queue; store contents are left as they are.
module double_ended_queue
    import deq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [CMD_W-1:0]         i_cmd,
    input  logic signed [DATA_W-1:0] i_value,
    output logic                     o_valid,
    output logic [STAT_W-1:0]        o_status,
    output logic signed [DATA_W-1:0] o_data,
    output logic [POS_W-1:0]         o_position,
    output logic                     o_last
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_POP  = 3'b010,
        S_DUMP = 3'b100
    } t_state;

    t_state              r_state, n_state;
    logic [AW-1:0]       r_front, n_front;
    logic [CW-1:0]       r_occ, n_occ;
    logic [AW-1:0]       r_idx, n_idx;
    logic                r_valid, n_valid;
    logic [STAT_W-1:0]   r_status, n_status;
    logic [DATA_W-1:0]   r_data, n_data;
    logic [POS_W-1:0]    r_pos, n_pos;
    logic                r_last, n_last;

    logic                we;
    logic [AW-1:0]       waddr;
    logic [AW-1:0]       raddr;
    logic [DATA_W-1:0]   rdata;
    logic                full;
    logic                empty;
    logic [CW-1:0]       idx_next;

    // Ring slot at a given offset from a base slot.
    function automatic logic [AW-1:0] wrap(input logic [AW-1:0] base, input logic [CW-1:0] off);
        logic [CW:0] sum;
        sum = (CW+1)'(base) + (CW+1)'(off);
        if (sum >= (CW+1)'(DEPTH)) begin
            sum = sum - (CW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    deq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (i_value),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign full     = (r_occ == CW'(DEPTH));
    assign empty    = (r_occ == '0);
    assign idx_next = CW'(r_idx) + CW'(1);

    always_comb begin
        n_state  = r_state;
        n_front  = r_front;
        n_occ    = r_occ;
        n_idx    = r_idx;
        n_valid  = 1'b0;
        n_status = ST_OK;
        n_data   = '0;
        n_pos    = '0;
        n_last   = 1'b1;
        we       = 1'b0;
        waddr    = r_front;
        raddr    = r_front;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    unique case (i_cmd)
                        CMD_PUSH_FRONT: begin
                            n_valid = 1'b1;
                            if (full) begin
                                n_status = ST_FULL;
                            end else begin
                                n_front = (r_front == '0) ? AW'(DEPTH - 1) : r_front - AW'(1);
                                waddr   = n_front;
                                we      = 1'b1;
                                n_occ   = r_occ + CW'(1);
                            end
                        end
                        CMD_PUSH_BACK: begin
                            n_valid = 1'b1;
                            if (full) begin
                                n_status = ST_FULL;
                            end else begin
                                waddr = wrap(r_front, r_occ);
                                we    = 1'b1;
                                n_occ = r_occ + CW'(1);
                            end
                        end
                        CMD_POP_FRONT: begin
                            if (empty) begin
                                n_valid  = 1'b1;
                                n_status = ST_EMPTY;
                            end else begin
                                raddr   = r_front;
                                n_front = wrap(r_front, CW'(1));
                                n_occ   = r_occ - CW'(1);
                                n_state = S_POP;
                            end
                        end
                        CMD_POP_BACK: begin
                            if (empty) begin
                                n_valid  = 1'b1;
                                n_status = ST_EMPTY;
                            end else begin
                                raddr   = wrap(r_front, r_occ - CW'(1));
                                n_occ   = r_occ - CW'(1);
                                n_state = S_POP;
                            end
                        end
                        CMD_DUMP: begin
                            if (empty) begin
                                n_valid  = 1'b1;
                                n_status = ST_EMPTY;
                            end else begin
                                raddr   = r_front;
                                n_idx   = '0;
                                n_state = S_DUMP;
                            end
                        end
                        default: begin
                            // Drop unknown commands without a result.
                        end
                    endcase
                end
            end
            S_POP: begin
                n_valid = 1'b1;
                n_data  = rdata;
                n_state = S_IDLE;
            end
            S_DUMP: begin
                // Emit the entry read last cycle and fetch the next one.
                n_valid = 1'b1;
                n_data  = rdata;
                n_pos   = POS_W'(r_idx);
                n_last  = (idx_next == r_occ);
                raddr   = wrap(r_front, idx_next);
                n_idx   = idx_next[AW-1:0];
                if (n_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_front <= '0;
            r_occ   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_front <= n_front;
            r_occ   <= n_occ;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_status <= n_status;
        r_data   <= n_data;
        r_pos    <= n_pos;
        r_last   <= n_last;
    end

    assign busy       = (r_state != S_IDLE);
    assign o_valid    = r_valid;
    assign o_status   = r_status;
    assign o_data     = r_data;
    assign o_position = r_pos;
    assign o_last     = r_last;

endmodule

[rtl/deq_checker.sv]
// Port-level checks for the double-ended queue, bound to the top level.
`include "double_ended_queue_defines.svh"

module deq_checker
    import deq_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     start,
    input logic                     busy,
    input logic [CMD_W-1:0]         i_cmd,
    input logic                     o_valid,
    input logic [STAT_W-1:0]        o_status,
    input logic signed [DATA_W-1:0] o_data,
    input logic [POS_W-1:0]         o_position,
    input logic                     o_last
);

    logic push_acc;
    logic push_res;
    logic err_res;
    logic err_zero;
    logic mid_dump;
    logic dump_ok;

    assign push_acc = start && !busy && (i_cmd == CMD_PUSH_FRONT || i_cmd == CMD_PUSH_BACK);
    assign push_res = o_valid && o_last && (o_status != ST_EMPTY);
    assign err_res  = o_valid && (o_status != ST_OK);
    assign err_zero = (o_data == '0) && (o_position == '0);
    assign mid_dump = o_valid && !o_last;
    assign dump_ok  = o_valid && (o_status == ST_OK);

    `DEQ_ASSERT_NEXT(a_push_result, i_clk, i_rst_n, push_acc, push_res, "push result missing")
    `DEQ_ASSERT_NOW(a_err_last, i_clk, i_rst_n, err_res, o_last, "error result not last")
    `DEQ_ASSERT_NOW(a_err_zero, i_clk, i_rst_n, err_res, err_zero, "error result carries data")
    `DEQ_ASSERT_NEXT(a_dump_run, i_clk, i_rst_n, mid_dump, dump_ok, "dump results not contiguous")

endmodule

bind double_ended_queue deq_checker u_deq_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .start      (start),
    .busy       (busy),
    .i_cmd      (i_cmd),
    .o_valid    (o_valid),
    .o_status   (o_status),
    .o_data     (o_data),
    .o_position (o_position),
    .o_last     (o_last)
);
